@@ src/mcconv_pkg.sv @@
`default_nettype none
// Shared types, codes and widths for the multichannel direct convolution block.
package mcconv_pkg;

  localparam int ACTION_W   = 2;
  localparam int INDEX_W    = 14;
  localparam int VALUE_W    = 16;
  localparam int POS_W      = 5;
  localparam int SUM_W      = 48;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam int IC_W       = 5;
  localparam int OC_W       = 6;
  localparam int DIM_W      = 6;
  localparam int K_W        = 2;
  localparam int PAD_W      = 2;
  localparam int STEP_W     = 3;
  localparam int MAX_STEP   = 4;

  // derived sizes, bounded by the register widths
  localparam int HW_W       = 2 * DIM_W;
  localparam int PER_OC_W   = IC_W + 2 * K_W;
  localparam int ACT_LIM_W  = IC_W + HW_W;
  localparam int WGT_LIM_W  = OC_W + PER_OC_W;
  localparam int SPAN_W     = 9;
  localparam int HI_W       = 9;
  localparam int ROW_W      = 16;
  localparam int ADDR_W     = 19;
  localparam int WCNT_W     = 16;

  localparam logic [ACTION_W-1:0] OP_LOAD_ACT = 2'd0;
  localparam logic [ACTION_W-1:0] OP_LOAD_WGT = 2'd1;
  localparam logic [ACTION_W-1:0] OP_COMPUTE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PADDING       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

@@ src/mcconv_if.sv @@
`default_nettype none
// Request and response channel interfaces of the convolution block.
interface mcconv_req_if;
  logic                                    valid;
  logic                                    ready;
  logic        [mcconv_pkg::ACTION_W-1:0]  action;
  logic        [mcconv_pkg::INDEX_W-1:0]   index;
  logic signed [mcconv_pkg::VALUE_W-1:0]   value;
  logic        [mcconv_pkg::POS_W-1:0]     out_chan;
  logic        [mcconv_pkg::POS_W-1:0]     out_row;
  logic        [mcconv_pkg::POS_W-1:0]     out_col;

  modport source (output valid, action, index, value, out_chan, out_row, out_col,
                  input ready);
  modport sink (input valid, action, index, value, out_chan, out_row, out_col,
                output ready);
endinterface

interface mcconv_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [mcconv_pkg::SUM_W-1:0] sum;
  logic                                status;

  modport source (output valid, sum, status, input ready);
  modport sink (input valid, sum, status, output ready);
endinterface
`default_nettype wire

@@ src/multichannel_conv2d_direct.sv @@
`default_nettype none
// Multichannel direct 2D convolution: activation and weight stores with one shared MAC.
//
// Loads write one word into the activation or weight store (accept, then the
// store write in ST_LOAD); they return no word. A compute request runs one
// multiply-accumulate per cycle over every input channel and kernel tap. It
// passes ST_CHECK, ST_SETUP, ST_RUN over the taps, ST_DRAIN and ST_DONE, where
// its word goes to the output register, and the next request is taken in
// ST_IDLE after that. Taps in the zero border are still walked and add zero.
// A position outside the output returns status 1 and sum 0, going from
// ST_SETUP straight to ST_DONE without a tap walk.
// The result sits in an output register, so the next request is taken while
// it waits. Stores have no reset; read only what has been loaded.
module multichannel_conv2d_direct #(
  parameter int MAX_IN_CHANNELS  = 16,
  parameter int MAX_OUT_CHANNELS = 32,
  parameter int MAX_HEIGHT       = 32,
  parameter int MAX_WIDTH        = 32,
  parameter int MAX_KERNEL       = 3,
  parameter int DATA_BITS        = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire [mcconv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [mcconv_pkg::CFG_DATA_W-1:0]     cfg_data,
  mcconv_req_if.sink                           req,
  mcconv_rsp_if.source                         rsp
);
  import mcconv_pkg::*;

  localparam int ACT_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int WGT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int AA_W      = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int WA_W      = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int PROD_W    = 2 * DATA_BITS;

  // configuration registers
  logic [IC_W-1:0]   cfg_in_ch;
  logic [OC_W-1:0]   cfg_out_ch;
  logic [DIM_W-1:0]  cfg_height;
  logic [DIM_W-1:0]  cfg_width;
  logic [K_W-1:0]    cfg_kh;
  logic [K_W-1:0]    cfg_kw;
  logic [PAD_W-1:0]  cfg_pad;
  logic [STEP_W-1:0] cfg_step;

  // clamped sizes
  logic [IC_W-1:0]   ic_n;
  logic [OC_W-1:0]   oc_n;
  logic [DIM_W-1:0]  h;
  logic [DIM_W-1:0]  w;
  logic [K_W-1:0]    kh;
  logic [K_W-1:0]    kw;
  logic [PAD_W-1:0]  pad;
  logic [STEP_W-1:0] st;

  logic [HW_W-1:0]      hw;
  logic [PER_OC_W-1:0]  per_oc;
  logic [ACT_LIM_W-1:0] act_lim;
  logic [WGT_LIM_W-1:0] wgt_lim;

  // latched request
  logic        [ACTION_W-1:0] req_action;
  logic        [INDEX_W-1:0]  req_index;
  logic signed [VALUE_W-1:0]  req_value;
  logic        [POS_W-1:0]    req_oc;
  logic        [POS_W-1:0]    req_row;
  logic        [POS_W-1:0]    req_col;

  state_t state, state_next;

  logic in_range;
  logic in_range_next;
  logic signed [HI_W-1:0] hi0, hi0_next;
  logic signed [HI_W-1:0] wi0, wi0_next;
  logic [SPAN_W-1:0] row_span, col_span, row_room, col_room;

  // tap walk
  logic [IC_W-1:0]         c;
  logic [K_W-1:0]          i;
  logic [K_W-1:0]          j;
  logic signed [HI_W-1:0]  hi;
  logic signed [HI_W-1:0]  wi;
  logic signed [ROW_W-1:0] row_off;
  logic signed [ROW_W-1:0] row_off0;
  logic [ADDR_W-1:0]       chan_base;
  logic [WCNT_W-1:0]       wcnt;
  logic [ADDR_W-1:0]       act_addr;
  logic                    tap_ok;
  logic                    last_tap;

  // MAC pipeline
  logic                     s1, t1, s2;
  logic signed [DATA_BITS-1:0] act_rd;
  logic signed [DATA_BITS-1:0] wgt_rd;
  logic signed [PROD_W-1:0]    prod;
  logic [SUM_W-1:0]            acc;
  logic                        status;

  logic out_valid;
  logic [SUM_W-1:0] out_sum;
  logic out_status;

  logic accept;
  logic issue;
  logic out_load;

  logic signed [DATA_BITS-1:0] act_mem [ACT_DEPTH];
  logic signed [DATA_BITS-1:0] wgt_mem [WGT_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_in_ch  <= 5'd16;
      cfg_out_ch <= 6'd32;
      cfg_height <= 6'd32;
      cfg_width  <= 6'd32;
      cfg_kh     <= 2'd3;
      cfg_kw     <= 2'd3;
      cfg_pad    <= 2'd1;
      cfg_step   <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IN_CHANNELS:   cfg_in_ch  <= cfg_data[IC_W-1:0];
        REG_OUT_CHANNELS:  cfg_out_ch <= cfg_data[OC_W-1:0];
        REG_HEIGHT:        cfg_height <= cfg_data[DIM_W-1:0];
        REG_WIDTH:         cfg_width  <= cfg_data[DIM_W-1:0];
        REG_KERNEL_HEIGHT: cfg_kh     <= cfg_data[K_W-1:0];
        REG_KERNEL_WIDTH:  cfg_kw     <= cfg_data[K_W-1:0];
        REG_PADDING:       cfg_pad    <= cfg_data[PAD_W-1:0];
        REG_STEP_SIZE:     cfg_step   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ic_n = (cfg_in_ch == '0) ? IC_W'(1) :
           (cfg_in_ch > MAX_IN_CHANNELS) ? IC_W'(MAX_IN_CHANNELS) : cfg_in_ch;
    oc_n = (cfg_out_ch == '0) ? OC_W'(1) :
           (cfg_out_ch > MAX_OUT_CHANNELS) ? OC_W'(MAX_OUT_CHANNELS) : cfg_out_ch;
    h    = (cfg_height == '0) ? DIM_W'(1) :
           (cfg_height > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : cfg_height;
    w    = (cfg_width == '0) ? DIM_W'(1) :
           (cfg_width > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cfg_width;
    kh   = (cfg_kh == '0) ? K_W'(1) : (cfg_kh > MAX_KERNEL) ? K_W'(MAX_KERNEL) : cfg_kh;
    kw   = (cfg_kw == '0) ? K_W'(1) : (cfg_kw > MAX_KERNEL) ? K_W'(MAX_KERNEL) : cfg_kw;
    pad  = (cfg_pad > MAX_KERNEL - 1) ? PAD_W'(MAX_KERNEL - 1) : cfg_pad;
    st   = (cfg_step == '0) ? STEP_W'(1) :
           (cfg_step > MAX_STEP) ? STEP_W'(MAX_STEP) : cfg_step;
  end

  always_ff @(posedge clk) begin
    hw     <= HW_W'(h) * HW_W'(w);
    per_oc <= PER_OC_W'(ic_n) * PER_OC_W'(kh) * PER_OC_W'(kw);
  end

  assign act_lim = ACT_LIM_W'(ic_n) * ACT_LIM_W'(hw);
  assign wgt_lim = WGT_LIM_W'(oc_n) * WGT_LIM_W'(per_oc);

  // output position check: row in range when row*step + kh <= h + 2*pad
  always_comb begin
    row_span      = SPAN_W'(req_row) * SPAN_W'(st) + SPAN_W'(kh);
    col_span      = SPAN_W'(req_col) * SPAN_W'(st) + SPAN_W'(kw);
    row_room      = SPAN_W'(h) + SPAN_W'({pad, 1'b0});
    col_room      = SPAN_W'(w) + SPAN_W'({pad, 1'b0});
    in_range_next = (OC_W'(req_oc) < oc_n) && (row_span <= row_room) &&
                    (col_span <= col_room);
    hi0_next      = HI_W'(req_row) * HI_W'(st) - HI_W'(pad);
    wi0_next      = HI_W'(req_col) * HI_W'(st) - HI_W'(pad);
  end

  always_comb begin
    tap_ok   = (hi >= 0) && (hi < $signed(HI_W'(h))) &&
               (wi >= 0) && (wi < $signed(HI_W'(w)));
    act_addr = ADDR_W'(chan_base) + ADDR_W'(row_off) + ADDR_W'(wi);
    last_tap = (c == ic_n - IC_W'(1)) && (i == kh - K_W'(1)) && (j == kw - K_W'(1));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          case (req.action)
            OP_LOAD_ACT, OP_LOAD_WGT: state_next = ST_LOAD;
            OP_COMPUTE:               state_next = ST_CHECK;
            default:                  state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:  state_next = ST_IDLE;
      ST_CHECK: state_next = ST_SETUP;
      ST_SETUP: state_next = in_range ? ST_RUN : ST_DONE;
      ST_RUN:   state_next = last_tap ? ST_DRAIN : ST_RUN;
      ST_DRAIN: state_next = (!s1 && !s2) ? ST_DONE : ST_DRAIN;
      ST_DONE:  state_next = (!out_valid || rsp.ready) ? ST_IDLE : ST_DONE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready = 1'b0;
    issue     = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_RUN:  issue = 1'b1;
      ST_DONE: out_load = !out_valid || rsp.ready;
      default: ;
    endcase
  end

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= req.action;
      req_index  <= req.index;
      req_value  <= req.value;
      req_oc     <= req.out_chan;
      req_row    <= req.out_row;
      req_col    <= req.out_col;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      in_range <= in_range_next;
      hi0      <= hi0_next;
      wi0      <= wi0_next;
    end
  end

  // tap walk over channel, kernel row, kernel column
  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      c         <= '0;
      i         <= '0;
      j         <= '0;
      hi        <= hi0;
      wi        <= wi0;
      row_off   <= ROW_W'(hi0) * ROW_W'($signed({1'b0, w}));
      row_off0  <= ROW_W'(hi0) * ROW_W'($signed({1'b0, w}));
      chan_base <= '0;
      wcnt      <= WCNT_W'(req_oc) * WCNT_W'(per_oc);
    end else if (issue) begin
      wcnt <= wcnt + WCNT_W'(1);
      if (j == kw - K_W'(1)) begin
        j  <= '0;
        wi <= wi0;
        if (i == kh - K_W'(1)) begin
          i         <= '0;
          hi        <= hi0;
          row_off   <= row_off0;
          c         <= c + IC_W'(1);
          chan_base <= chan_base + ADDR_W'(hw);
        end else begin
          i       <= i + K_W'(1);
          hi      <= hi + HI_W'(1);
          row_off <= row_off + ROW_W'($signed({1'b0, w}));
        end
      end else begin
        j  <= j + K_W'(1);
        wi <= wi + HI_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && req_action == OP_LOAD_ACT &&
        ACT_LIM_W'(req_index) < act_lim && req_index < ACT_DEPTH) begin
      act_mem[AA_W'(req_index)] <= DATA_BITS'(req_value);
    end
    if (issue) begin
      act_rd <= act_mem[AA_W'(act_addr)];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && req_action == OP_LOAD_WGT &&
        WGT_LIM_W'(req_index) < wgt_lim && req_index < WGT_DEPTH) begin
      wgt_mem[WA_W'(req_index)] <= DATA_BITS'(req_value);
    end
    if (issue) begin
      wgt_rd <= wgt_mem[WA_W'(wcnt)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= 1'b0;
      t1 <= 1'b0;
      s2 <= 1'b0;
    end else begin
      s1 <= issue;
      t1 <= issue && tap_ok;
      s2 <= s1;
    end
  end

  // border taps multiply to zero
  always_ff @(posedge clk) begin
    if (s1) begin
      if (t1) begin
        prod <= act_rd * wgt_rd;
      end else begin
        prod <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      status <= 1'b0;
    end else if (state == ST_SETUP) begin
      acc    <= '0;
      status <= !in_range;
    end else if (s2) begin
      acc <= acc + SUM_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sum    <= acc;
      out_status <= status;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.sum    = out_sum;
  assign rsp.status = out_status;

endmodule
`default_nettype wire

@@ tb/multichannel_conv2d_direct_tb.sv @@
// Self-checking testbench for the multichannel direct 2D convolution block.
import mcconv_pkg::*;

typedef struct packed {
  logic [ACTION_W-1:0]       action;
  logic [INDEX_W-1:0]        index;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          chan;
  logic [POS_W-1:0]          row;
  logic [POS_W-1:0]          col;
} word_t;

typedef struct packed {
  logic signed [SUM_W-1:0] sum;
  logic                    status;
} result_t;

class conv_scoreboard;
  localparam int ACT_DEPTH = 16384;
  localparam int WGT_DEPTH = 4608;
  localparam int MAX_IC    = 16;
  localparam int MAX_OC    = 32;
  localparam int MAX_DIM   = 32;
  localparam int MAX_K     = 3;

  logic signed [VALUE_W-1:0] act_mem [ACT_DEPTH];
  logic signed [VALUE_W-1:0] wgt_mem [WGT_DEPTH];
  bit                        act_set [ACT_DEPTH];
  bit                        wgt_set [WGT_DEPTH];

  int ic_n, oc_n, h_n, w_n, kh_n, kw_n, pad_n, st_n, oh_n, ow_n;
  result_t sums_due [$];
  int faults;

  function new();
    faults = 0;
    st_n   = 1;
    set_reg(REG_IN_CHANNELS, 16);
    set_reg(REG_OUT_CHANNELS, 32);
    set_reg(REG_HEIGHT, 32);
    set_reg(REG_WIDTH, 32);
    set_reg(REG_KERNEL_HEIGHT, 3);
    set_reg(REG_KERNEL_WIDTH, 3);
    set_reg(REG_PADDING, 1);
    set_reg(REG_STEP_SIZE, 1);
  endfunction

  function int clamp(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_IN_CHANNELS:   ic_n  = clamp(int'(data[IC_W-1:0]), 1, MAX_IC);
      REG_OUT_CHANNELS:  oc_n  = clamp(int'(data[OC_W-1:0]), 1, MAX_OC);
      REG_HEIGHT:        h_n   = clamp(int'(data[DIM_W-1:0]), 1, MAX_DIM);
      REG_WIDTH:         w_n   = clamp(int'(data[DIM_W-1:0]), 1, MAX_DIM);
      REG_KERNEL_HEIGHT: kh_n  = clamp(int'(data[K_W-1:0]), 1, MAX_K);
      REG_KERNEL_WIDTH:  kw_n  = clamp(int'(data[K_W-1:0]), 1, MAX_K);
      REG_PADDING:       pad_n = clamp(int'(data[PAD_W-1:0]), 0, MAX_K - 1);
      REG_STEP_SIZE:     st_n  = clamp(int'(data[STEP_W-1:0]), 1, MAX_STEP);
      default: ;
    endcase
    oh_n = (h_n + 2 * pad_n >= kh_n) ? (h_n + 2 * pad_n - kh_n) / st_n + 1 : 0;
    ow_n = (w_n + 2 * pad_n >= kw_n) ? (w_n + 2 * pad_n - kw_n) / st_n + 1 : 0;
  endfunction

  function bit load_lands(word_t w);
    if (w.action == OP_LOAD_ACT)
      return int'(w.index) < ic_n * h_n * w_n;
    if (w.action == OP_LOAD_WGT)
      return int'(w.index) < oc_n * ic_n * kh_n * kw_n && int'(w.index) < WGT_DEPTH;
    return 1'b0;
  endfunction

  function bit in_output(int ch, int row, int col);
    return ch < oc_n && row < oh_n && col < ow_n;
  endfunction

  // store addresses of one tap; false when the tap falls in the zero border
  function bit tap_index(int ch, int row, int col, int c, int i, int j,
                         output int ai, output int wj);
    int hi, wi;
    hi = row * st_n + i - pad_n;
    wi = col * st_n + j - pad_n;
    ai = c * h_n * w_n + hi * w_n + wi;
    wj = ((ch * ic_n + c) * kh_n + i) * kw_n + j;
    return hi >= 0 && hi < h_n && wi >= 0 && wi < w_n && ai < ACT_DEPTH && wj < WGT_DEPTH;
  endfunction

  function void note_word(word_t w);
    result_t want;
    longint  acc;
    int      ai, wj;
    if (w.action == OP_LOAD_ACT && load_lands(w)) begin
      act_mem[w.index] = w.value;
      act_set[w.index] = 1'b1;
    end else if (w.action == OP_LOAD_WGT && load_lands(w)) begin
      wgt_mem[w.index] = w.value;
      wgt_set[w.index] = 1'b1;
    end else if (w.action == OP_COMPUTE) begin
      if (!in_output(w.chan, w.row, w.col)) begin
        want.sum    = '0;
        want.status = 1'b1;
      end else begin
        acc = 0;
        for (int c = 0; c < ic_n; c++)
          for (int i = 0; i < kh_n; i++)
            for (int j = 0; j < kw_n; j++)
              if (tap_index(w.chan, w.row, w.col, c, i, j, ai, wj))
                acc += longint'(act_mem[ai]) * longint'(wgt_mem[wj]);
        want.sum    = acc[SUM_W-1:0];
        want.status = 1'b0;
      end
      sums_due.push_back(want);
    end
  endfunction

  function void flag(string what, longint want, longint got);
    faults++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endfunction

  function void check_word(logic signed [SUM_W-1:0] sum, logic status);
    result_t want;
    if (sums_due.size() == 0) begin
      faults++;
      $display("%0t: unexpected word, expected none, got sum %0d status %0b",
               $time, sum, status);
      return;
    end
    want = sums_due.pop_front();
    if (sum !== want.sum)
      flag("sum", want.sum, sum);
    if (status !== want.status)
      flag("status", want.status, status);
  endfunction
endclass

module multichannel_conv2d_direct_tb;
  localparam logic [ACTION_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 700;
  localparam int PHASE_WORDS  = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int WATCHDOG     = 4000;
  localparam int SETTLE       = 10;
  localparam int TAIL         = 200;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic [CFG_DATA_W-1:0] cfg_plan [8];

  mcconv_req_if req_bus ();
  mcconv_rsp_if rsp_bus ();

  conv_scoreboard sb = new();

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int words_fed = 0;
  int quiet_cycles = 0;
  bit hold_rsp = 1'b0;

  multichannel_conv2d_direct u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_bus),
    .rsp       (rsp_bus)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : rsp_side
    int hold_left;
    hold_left = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid && rsp_bus.ready)
        sb.check_word(rsp_bus.sum, rsp_bus.status);
      if (hold_rsp) begin
        hold_left = HOLD_CYCLES;
        hold_rsp  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_cfg(logic [CFG_IDX_W-1:0] idx);
    int r;
    r = $urandom_range(99);
    case (idx)
      REG_IN_CHANNELS:
        return CFG_DATA_W'(r < 6 ? 0 : r < 10 ? $urandom_range(31, 17) :
                           r < 16 ? 16 : $urandom_range(3, 1));
      REG_OUT_CHANNELS:
        return CFG_DATA_W'(r < 6 ? 0 : r < 10 ? $urandom_range(63, 33) :
                           r < 16 ? 32 : $urandom_range(4, 1));
      REG_HEIGHT, REG_WIDTH:
        return CFG_DATA_W'(r < 6 ? 0 : r < 10 ? $urandom_range(63, 33) :
                           r < 20 ? 32 : $urandom_range(6, 1));
      REG_KERNEL_HEIGHT, REG_KERNEL_WIDTH, REG_PADDING:
        return CFG_DATA_W'($urandom_range(3));
      default:
        return CFG_DATA_W'($urandom_range(7));
    endcase
  endfunction

  task automatic push_word(word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.action   <= w.action;
    req_bus.index    <= w.index;
    req_bus.value    <= w.value;
    req_bus.out_chan <= w.chan;
    req_bus.out_row  <= w.row;
    req_bus.out_col  <= w.col;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    sb.note_word(w);
    if (w.action == OP_COMPUTE || sb.load_lands(w))
      words_fed++;
  endtask

  task automatic load_word(logic [ACTION_W-1:0] act, int index,
                           logic signed [VALUE_W-1:0] value);
    word_t w;
    w.action = act;
    w.index  = INDEX_W'(index);
    w.value  = value;
    w.chan   = POS_W'($urandom);
    w.row    = POS_W'($urandom);
    w.col    = POS_W'($urandom);
    push_word(w);
  endtask

  // loads any tap not yet written (and some at random) before the request
  task automatic ask_output(int ch, int row, int col, int reload_pct);
    int    ai, wj;
    word_t w;
    if (sb.in_output(ch, row, col))
      for (int c = 0; c < sb.ic_n; c++)
        for (int i = 0; i < sb.kh_n; i++)
          for (int j = 0; j < sb.kw_n; j++)
            if (sb.tap_index(ch, row, col, c, i, j, ai, wj)) begin
              if (!sb.act_set[ai] || $urandom_range(99) < reload_pct)
                load_word(OP_LOAD_ACT, ai, rand_value());
              if (!sb.wgt_set[wj] || $urandom_range(99) < reload_pct)
                load_word(OP_LOAD_WGT, wj, rand_value());
            end
    w.action = OP_COMPUTE;
    w.index  = INDEX_W'($urandom);
    w.value  = VALUE_W'($urandom);
    w.chan   = POS_W'(ch);
    w.row    = POS_W'(row);
    w.col    = POS_W'(col);
    push_word(w);
  endtask

  task automatic settle();
    req_bus.valid <= 1'b0;
    while (sb.sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs();
    for (int k = 0; k < 8; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data  <= cfg_plan[k];
      @(posedge clk);
      sb.set_reg(CFG_IDX_W'(k), cfg_plan[k]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int    r, phase_start;
    word_t w;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    req_bus.valid    = 1'b0;
    req_bus.action   = OP_LOAD_ACT;
    req_bus.index    = '0;
    req_bus.value    = '0;
    req_bus.out_chan = '0;
    req_bus.out_row  = '0;
    req_bus.out_col  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one channel, 2x2 image, 2x2 kernel: a single output position
    cfg_plan[REG_IN_CHANNELS]   = 1;
    cfg_plan[REG_OUT_CHANNELS]  = 1;
    cfg_plan[REG_HEIGHT]        = 2;
    cfg_plan[REG_WIDTH]         = 2;
    cfg_plan[REG_KERNEL_HEIGHT] = 2;
    cfg_plan[REG_KERNEL_WIDTH]  = 2;
    cfg_plan[REG_PADDING]       = 0;
    cfg_plan[REG_STEP_SIZE]     = 1;
    program_regs();
    for (int k = 0; k < 4; k++)
      load_word(OP_LOAD_ACT, k, 16'sh8000);
    load_word(OP_LOAD_WGT, 0, 16'sh8000);
    load_word(OP_LOAD_WGT, 1, 16'sh8000);
    load_word(OP_LOAD_WGT, 2, 16'sh7fff);
    load_word(OP_LOAD_WGT, 3, 16'sh7fff);
    // loads past the configured size are dropped
    load_word(OP_LOAD_ACT, 4, 16'sh1234);
    load_word(OP_LOAD_ACT, 16383, 16'sh7fff);
    load_word(OP_LOAD_WGT, 4, 16'sh1234);
    load_word(OP_LOAD_WGT, 16383, 16'sh7fff);
    w = '{action: OP_UNUSED, index: '1, value: '1, chan: '1, row: '1, col: '1};
    push_word(w);
    ask_output(0, 0, 0, 0);
    ask_output(31, 31, 31, 0);
    ask_output(1, 0, 0, 0);
    ask_output(0, 1, 0, 0);
    ask_output(0, 0, 1, 0);
    ask_output(0, 0, 0, 0);

    // response side stalls long enough for the request side to back up
    hold_rsp = 1'b1;
    repeat (6) ask_output(0, 0, 0, 0);

    words_fed = 0;
    for (int p = 0; words_fed < RANDOM_WORDS; p++) begin
      settle();
      for (int k = 0; k < 8; k++)
        cfg_plan[k] = (p == 0) ? '1 : (p == 1) ? '0 : pick_cfg(CFG_IDX_W'(k));
      if (p == 0)
        cfg_plan[REG_WIDTH] = 32;
      program_regs();
      phase_start = words_fed;
      while (words_fed - phase_start < PHASE_WORDS) begin
        src_idle_pct = words_fed < RANDOM_WORDS / 3 ? 12 : words_fed < 2 * RANDOM_WORDS / 3 ? 67 : 0;
        snk_idle_pct = words_fed < RANDOM_WORDS / 3 ? 67 : words_fed < 2 * RANDOM_WORDS / 3 ? 12 : 0;
        r = $urandom_range(99);
        if (r < 8) begin
          load_word($urandom_range(1) ? OP_LOAD_WGT : OP_LOAD_ACT, $urandom_range(16383),
                    rand_value());
        end else if (r < 11) begin
          w = '{action: OP_UNUSED, index: INDEX_W'($urandom), value: VALUE_W'($urandom),
                chan: POS_W'($urandom), row: POS_W'($urandom), col: POS_W'($urandom)};
          push_word(w);
        end else if (r < 26 || sb.oh_n == 0 || sb.ow_n == 0) begin
          ask_output($urandom_range(31), $urandom_range(31), $urandom_range(31), 20);
        end else begin
          ask_output($urandom_range(sb.oc_n - 1),
                     $urandom_range((sb.oh_n > 32 ? 32 : sb.oh_n) - 1),
                     $urandom_range((sb.ow_n > 32 ? 32 : sb.ow_n) - 1), 20);
        end
      end
    end

    settle();
    repeat (TAIL) @(posedge clk);
    if (sb.faults == 0 && sb.sums_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

@@ files.f @@
src/mcconv_pkg.sv
src/mcconv_if.sv
src/multichannel_conv2d_direct.sv
tb/multichannel_conv2d_direct_tb.sv
